### sv/kcl_pkg.sv
// Package for the keypad combination lock.
// Holds key codes, field widths and the transaction type shared by all files.
// No dependencies.
package kcl_pkg;

   localparam int KEY_W   = 8;
   localparam int DISP_W  = 3;
   localparam int INDEX_W = 3;

   localparam logic [KEY_W-1:0] KEY_NONE     = 8'h00;
   localparam logic [KEY_W-1:0] KEY_HASH     = 8'h23;
   localparam logic [KEY_W-1:0] KEY_STAR     = 8'h2A;
   localparam logic [KEY_W-1:0] KEY_DIGIT_ONE = 8'h31;

   localparam logic [DISP_W-1:0] DISP_LOCKED    = 3'd0;
   localparam logic [DISP_W-1:0] DISP_UNLOCKED  = 3'd1;
   localparam logic [DISP_W-1:0] DISP_REPROGRAM = 3'd5;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             button;
   } kcl_item_type;

endpackage

### sv/kcl_if.sv
// Valid/ready channel interfaces for the keypad combination lock.
// Depends on kcl_pkg for the field widths.
interface kcl_req_if
   import kcl_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key;
   logic             button;

   modport source (output valid, output key, output button, input ready);
   modport sink   (input valid, input key, input button, output ready);
endinterface

interface kcl_rsp_if
   import kcl_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DISP_W-1:0] display;
   logic              locked;

   modport source (output valid, output display, output locked, input ready);
   modport sink   (input valid, input display, input locked, output ready);
endinterface

### sv/kcl_in_stage.sv
// Input register stage of the keypad combination lock.
// Depends on kcl_pkg and the kcl_req_if interface.
module kcl_in_stage
   import kcl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   kcl_req_if.sink       req_chan,
   input  logic          take,
   output logic          item_valid,
   output kcl_item_type  item
);

   logic         valid_ff;
   logic         valid_in;
   kcl_item_type item_ff;
   logic         load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.key    <= req_chan.key;
         item_ff.button <= req_chan.button;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### sv/kcl_core.sv
// Lock state machine, code store and result register of the keypad combination lock.
// Depends on kcl_pkg and the kcl_rsp_if interface.
module kcl_core
   import kcl_pkg::*;
#(
   parameter int CODE_LENGTH = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  kcl_item_type  item,
   output logic          take,
   kcl_rsp_if.source     rsp_chan
);

   localparam int IDX_W = $clog2(CODE_LENGTH);
   localparam logic [INDEX_W-1:0] LAST = INDEX_W'(CODE_LENGTH);

   localparam logic [3:0] ST_START   = 4'd0;
   localparam logic [3:0] ST_WAIT    = 4'd1;
   localparam logic [3:0] ST_INPUT   = 4'd2;
   localparam logic [3:0] ST_HOLD    = 4'd3;
   localparam logic [3:0] ST_UNLOCK  = 4'd4;
   localparam logic [3:0] ST_WAITB   = 4'd5;
   localparam logic [3:0] ST_RESET   = 4'd6;
   localparam logic [3:0] ST_NEWCOMB = 4'd7;
   localparam logic [3:0] ST_HOLDNEW = 4'd8;

   logic [3:0]                        state_ff, state_in;
   logic [INDEX_W-1:0]                index_ff, index_in;
   logic                              locked_ff, locked_in;
   logic [DISP_W-1:0]                 display_ff, display_in;
   logic [CODE_LENGTH-1:0][KEY_W-1:0] code_ff;
   logic                              code_we;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [DISP_W-1:0]                 rsp_display_ff;
   logic                              rsp_locked_ff;
   logic                              fire;
   logic                              in_range;
   logic                              match;
   logic [INDEX_W-1:0]                index_inc;
   logic                              key_none;

   assign take     = item_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign fire     = take;
   assign key_none = (item.key == KEY_NONE);
   assign in_range = (index_ff < LAST);
   assign match    = in_range && (item.key == code_ff[index_ff[IDX_W-1:0]]);
   assign index_inc = index_ff + 3'd1;

   always_comb begin
      state_in   = state_ff;
      index_in   = index_ff;
      locked_in  = locked_ff;
      display_in = display_ff;
      code_we    = 1'b0;
      case (state_ff)
         ST_START: begin
            index_in   = '0;
            locked_in  = 1'b0;
            display_in = DISP_UNLOCKED;
            state_in   = ST_WAIT;
         end
         ST_WAIT: begin
            if (item.key == KEY_HASH) begin
               index_in = '0;
               state_in = ST_HOLD;
            end else if (item.button && !locked_ff) begin
               state_in   = ST_WAITB;
               display_in = DISP_LOCKED;
               locked_in  = 1'b1;
            end else if (item.button && item.key == KEY_STAR) begin
               state_in   = ST_RESET;
               index_in   = '0;
               display_in = DISP_REPROGRAM;
            end
         end
         ST_INPUT: begin
            if (match) begin
               index_in = index_inc;
               if (index_inc < LAST) begin
                  state_in = ST_HOLD;
               end else begin
                  state_in   = ST_UNLOCK;
                  display_in = DISP_UNLOCKED;
                  locked_in  = 1'b0;
               end
            end else if (!key_none) begin
               display_in = DISP_LOCKED;
               state_in   = ST_WAIT;
            end
         end
         ST_HOLD: begin
            if (key_none) begin
               state_in = ST_INPUT;
            end
         end
         ST_WAITB: begin
            if (!item.button) begin
               state_in = ST_WAIT;
            end
         end
         ST_UNLOCK: begin
            state_in = ST_WAIT;
         end
         ST_RESET: begin
            if (!item.button && key_none) begin
               state_in = ST_NEWCOMB;
            end
         end
         ST_NEWCOMB: begin
            if (in_range) begin
               if (!key_none) begin
                  code_we    = 1'b1;
                  index_in   = index_inc;
                  display_in = index_inc;
                  state_in   = ST_HOLDNEW;
               end
            end else begin
               state_in   = ST_WAIT;
               display_in = DISP_LOCKED;
            end
         end
         ST_HOLDNEW: begin
            if (key_none) begin
               state_in = ST_NEWCOMB;
            end
         end
         default: begin
            state_in = ST_START;
         end
      endcase
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_START;
         index_ff     <= '0;
         locked_ff    <= 1'b0;
         display_ff   <= DISP_LOCKED;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CODE_LENGTH; i++) begin
            code_ff[i] <= KEY_DIGIT_ONE + KEY_W'(i);
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff   <= state_in;
            index_ff   <= index_in;
            locked_ff  <= locked_in;
            display_ff <= display_in;
            if (code_we) begin
               code_ff[index_ff[IDX_W-1:0]] <= item.key;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_display_ff <= display_in;
         rsp_locked_ff  <= locked_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.display = rsp_display_ff;
   assign rsp_chan.locked  = rsp_locked_ff;

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      index_ff <= LAST)
      else $error("Digit index has run past the code length.");

   a_unlock_returns: assert property (@(posedge clock) disable iff (reset)
      (fire && state_ff == ST_UNLOCK) |=> (state_ff == ST_WAIT))
      else $error("Unlock state did not return to waiting.");

   a_locked_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_locked_ff == locked_ff))
      else $error("Pending result disagrees with the locked flag.");

   a_count_shown: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && state_ff == ST_HOLDNEW) |-> (rsp_display_ff == index_ff))
      else $error("Reprogramming count not shown on the display.");

   a_code_stable: assert property (@(posedge clock) disable iff (reset)
      !(fire && state_ff == ST_NEWCOMB) |=> $stable(code_ff))
      else $error("Code store changed outside reprogramming.");

endmodule

### sv/keypad_combination_lock.sv
// Keypad combination lock: one keypad scan transaction in, one result transaction out.
// An accepted transaction passes through the input register, then the result register.
// Throughput is one transaction per cycle; a held result stalls input only when both
// registers are full.
// Synchronous reset clears the state machine and flags and reloads the code with '1' upwards.
// Depends on kcl_pkg, kcl_if, kcl_in_stage and kcl_core.
module keypad_combination_lock
   import kcl_pkg::*;
#(
   parameter int CODE_LENGTH = 5
) (
   input  logic      clock,
   input  logic      reset,
   kcl_req_if.sink   req_chan,
   kcl_rsp_if.source rsp_chan
);

   logic         take;
   logic         item_valid;
   kcl_item_type item;

   kcl_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   kcl_core #(
      .CODE_LENGTH (CODE_LENGTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_chan   (rsp_chan)
   );

endmodule

### tb/keypad_combination_lock_tb.sv
// Testbench for the keypad combination lock: drives keypad scan transactions, predicts each
// result with a scoreboard class and checks every result transaction against it.
// Depends on kcl_pkg, kcl_if and the keypad_combination_lock top level.
`timescale 1ns / 1ps

module keypad_combination_lock_tb;
   import kcl_pkg::*;

   localparam int CODE_LENGTH = 5;
   localparam int SCAN_COUNT  = 1500;

   typedef enum logic [3:0] {
      LS_START     = 4'd0,
      LS_WAIT      = 4'd1,
      LS_ENTRY     = 4'd2,
      LS_KEY_HELD  = 4'd3,
      LS_OPEN      = 4'd4,
      LS_BTN_HELD  = 4'd5,
      LS_PROG_ARM  = 4'd6,
      LS_PROG_KEY  = 4'd7,
      LS_PROG_HELD = 4'd8
   } lock_state_type;

   typedef struct {
      logic [DISP_W-1:0] display;
      logic              locked;
   } lock_result_type;

   class lock_scoreboard_type;
      lock_state_type     state;
      logic [INDEX_W-1:0] index;
      logic [KEY_W-1:0]   code_digits [CODE_LENGTH];
      logic               is_locked;
      logic [DISP_W-1:0]  disp;
      lock_result_type    pending_results [$];
      int                 mismatches;

      function new();
         state      = LS_START;
         index      = '0;
         is_locked  = 1'b0;
         disp       = DISP_LOCKED;
         mismatches = 0;
         for (int i = 0; i < CODE_LENGTH; i++) begin
            code_digits[i] = KEY_DIGIT_ONE + KEY_W'(i);
         end
      endfunction

      task report(string what);
         $display("%0t: mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      function void note_scan(logic [KEY_W-1:0] key, logic button);
         logic [INDEX_W-1:0] idx;
         lock_result_type    res;
         idx = index;
         case (state)
            LS_START: begin
               index     = '0;
               is_locked = 1'b0;
               disp      = DISP_UNLOCKED;
               state     = LS_WAIT;
            end
            LS_WAIT: begin
               if (key == KEY_HASH) begin
                  index = '0;
                  state = LS_KEY_HELD;
               end else if (button && !is_locked) begin
                  state     = LS_BTN_HELD;
                  disp      = DISP_LOCKED;
                  is_locked = 1'b1;
               end else if (button && key == KEY_STAR) begin
                  state = LS_PROG_ARM;
                  index = '0;
                  disp  = DISP_REPROGRAM;
               end
            end
            LS_ENTRY: begin
               if (idx < CODE_LENGTH && key == code_digits[idx]) begin
                  index = idx + 3'd1;
                  if (int'(idx) + 1 < CODE_LENGTH) begin
                     state = LS_KEY_HELD;
                  end else begin
                     state     = LS_OPEN;
                     disp      = DISP_UNLOCKED;
                     is_locked = 1'b0;
                  end
               end else if (key != KEY_NONE) begin
                  disp  = DISP_LOCKED;
                  state = LS_WAIT;
               end
            end
            LS_KEY_HELD: begin
               if (key == KEY_NONE) state = LS_ENTRY;
            end
            LS_BTN_HELD: begin
               if (!button) state = LS_WAIT;
            end
            LS_OPEN: begin
               state = LS_WAIT;
            end
            LS_PROG_ARM: begin
               if (!button && key == KEY_NONE) state = LS_PROG_KEY;
            end
            LS_PROG_KEY: begin
               if (idx < CODE_LENGTH) begin
                  if (key != KEY_NONE) begin
                     code_digits[idx] = key;
                     index            = idx + 3'd1;
                     disp             = index;
                     state            = LS_PROG_HELD;
                  end
               end else begin
                  state = LS_WAIT;
                  disp  = DISP_LOCKED;
               end
            end
            LS_PROG_HELD: begin
               if (key == KEY_NONE) state = LS_PROG_KEY;
            end
            default: begin
               state = LS_START;
            end
         endcase
         res.display = disp;
         res.locked  = is_locked;
         pending_results.push_back(res);
      endfunction

      task check_result(logic [DISP_W-1:0] display, logic locked);
         lock_result_type want;
         if (pending_results.size() == 0) begin
            report("result transaction with nothing expected");
         end else begin
            want = pending_results.pop_front();
            if (display !== want.display) begin
               report($sformatf("display %0d, expected %0d", display, want.display));
            end
            if (locked !== want.locked) begin
               report($sformatf("locked %0b, expected %0b", locked, want.locked));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset;
   bit   idling_on;
   int   scans_sent;

   lock_scoreboard_type sb;

   kcl_req_if req_chan ();
   kcl_rsp_if rsp_chan ();

   keypad_combination_lock #(
      .CODE_LENGTH (CODE_LENGTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         sb.check_result(rsp_chan.display, rsp_chan.locked);
      end
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !(idling_on && $urandom_range(99) < 7);
      end
   end

   task send_scan(logic [KEY_W-1:0] key, logic button);
      if (idling_on && $urandom_range(99) < 7) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.key    <= key;
      req_chan.button <= button;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_scan(key, button);
      scans_sent++;
   endtask

   // A key press held for one or more scans, then released.
   task tap_key(logic [KEY_W-1:0] key);
      repeat (($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1) send_scan(key, 1'b0);
      repeat ($urandom_range(1, 2)) send_scan(KEY_NONE, 1'b0);
   endtask

   task try_code(bit corrupt);
      int               bad_pos;
      logic [KEY_W-1:0] wrong;
      bad_pos = corrupt ? $urandom_range(0, CODE_LENGTH - 1) : CODE_LENGTH;
      tap_key(KEY_HASH);
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (i == bad_pos) begin
            do wrong = KEY_W'($urandom_range(1, 255)); while (wrong == sb.code_digits[i]);
            tap_key(wrong);
            return;
         end
         tap_key(sb.code_digits[i]);
      end
   endtask

   task press_lock();
      repeat ($urandom_range(1, 3)) send_scan(KEY_NONE, 1'b1);
      send_scan(KEY_NONE, 1'b0);
   endtask

   task reprogram();
      logic [KEY_W-1:0] fresh;
      if (!sb.is_locked) press_lock();
      repeat ($urandom_range(1, 2)) send_scan(KEY_STAR, 1'b1);
      if ($urandom_range(1) == 0) send_scan(KEY_NONE, 1'b1);
      send_scan(KEY_NONE, 1'b0);
      for (int i = 0; i < CODE_LENGTH; i++) begin
         case ($urandom_range(7))
            0:       fresh = KEY_W'($urandom_range(1, 255));
            1:       fresh = KEY_HASH;
            2:       fresh = KEY_STAR;
            default: fresh = 8'h30 + KEY_W'($urandom_range(0, 9));
         endcase
         tap_key(fresh);
      end
      send_scan(($urandom_range(1) == 0) ? KEY_NONE : KEY_W'($urandom_range(0, 255)), 1'b0);
   endtask

   task noise_burst();
      logic [KEY_W-1:0] key;
      repeat ($urandom_range(1, 8)) begin
         key = ($urandom_range(2) == 0) ? KEY_NONE : KEY_W'($urandom_range(0, 255));
         send_scan(key, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      sb         = new();
      idling_on  = 1'b1;
      scans_sent = 0;
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.key    <= KEY_NONE;
      req_chan.button <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Start-up scan, the reset code entered, then a lock and a reprogram with extreme keys.
      send_scan(8'hFF, 1'b1);
      send_scan(KEY_HASH, 1'b0);
      send_scan(KEY_NONE, 1'b0);
      for (int i = 0; i < CODE_LENGTH; i++) begin
         send_scan(sb.code_digits[i], 1'b0);
         send_scan(KEY_NONE, 1'b0);
      end
      send_scan(KEY_NONE, 1'b1);
      send_scan(KEY_NONE, 1'b0);
      send_scan(KEY_STAR, 1'b1);
      send_scan(KEY_NONE, 1'b0);
      send_scan(8'h01, 1'b0);
      send_scan(KEY_NONE, 1'b0);
      send_scan(8'hFF, 1'b0);
      send_scan(KEY_NONE, 1'b0);
      send_scan(8'h37, 1'b0);
      send_scan(KEY_NONE, 1'b0);
      send_scan(8'h38, 1'b0);
      send_scan(KEY_NONE, 1'b0);
      send_scan(8'h39, 1'b0);
      send_scan(KEY_NONE, 1'b0);
      send_scan(KEY_NONE, 1'b0);

      while (scans_sent < SCAN_COUNT) begin
         idling_on = !(scans_sent >= 400 && scans_sent < 800);
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7: try_code(1'b0);
            8, 9:                   try_code(1'b1);
            10, 11, 12:             press_lock();
            13, 14, 15:             reprogram();
            default:                noise_burst();
         endcase
      end

      req_chan.valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
